>>> hw/rtl/segment_line_intersection_assert.svh
// Assertion macros for the segment / clipping-line intersection block.
// Each macro expects clk and rst (synchronous, active high) in scope.
`ifndef SEGMENT_LINE_INTERSECTION_ASSERT_SVH
`define SEGMENT_LINE_INTERSECTION_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SLI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sli_pkg.sv
// Shared constants for the segment / clipping-line intersection block.
// No dependencies; imported by the multiplier, the top level, the checker and the testbench.
`timescale 1ns / 1ps

package sli_pkg;

  // Multiplier digit width: one digit of b of this many bits per stage
  localparam int MUL_CHUNK = 16;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_NEAR_DEPTH = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_FAR_DEPTH  = 1'b1;

  // Register reset values (raw fixed point; far depth is 5.0 in Q16.16)
  localparam longint NEAR_DEPTH_RST = 7;
  localparam longint FAR_DEPTH_RST  = 327680;

  // Result flag bits on the master tuser
  localparam int USER_W         = 2;
  localparam int USER_PARALLEL  = 0;
  localparam int USER_SATURATED = 1;

endpackage

>>> hw/rtl/sli_delay.sv
// Enabled delay line that keeps side data aligned with the arithmetic stages.
// No package dependencies.
`timescale 1ns / 1ps

module sli_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] taps [DEPTH];

  // Shift one place per advancing cycle
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[DEPTH-1];

endmodule

>>> hw/rtl/sli_mul.sv
// Pipelined signed multiplier: one MUL_CHUNK-bit digit of b per stage.
// Depends on sli_pkg for the digit width.
`timescale 1ns / 1ps

module sli_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);
  import sli_pkg::*;

  localparam int NCH   = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int BP    = NCH * MUL_CHUNK;
  localparam int PW    = AW + BP;
  localparam int NPASS = (NCH > 1) ? NCH - 1 : 1;

  logic signed [AW-1:0] a_st   [NPASS];
  logic signed [BP-1:0] b_st   [NPASS];
  logic signed [PW-1:0] acc_st [NCH];

  for (genvar k = 0; k < NCH; k++) begin : g_step
    logic signed [AW-1:0]          a_in;
    logic signed [BP-1:0]          b_in;
    logic signed [PW-1:0]          acc_in;
    logic signed [MUL_CHUNK:0]     digit;
    logic signed [AW+MUL_CHUNK:0]  part;

    // Select this step's operands
    if (k == 0) begin : g_first
      assign a_in   = a;
      assign b_in   = BP'(b);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_st[k-1];
      assign b_in   = b_st[k-1];
      assign acc_in = acc_st[k-1];
    end

    // Top digit carries the sign, lower digits are unsigned
    if (k == NCH - 1) begin : g_top
      assign digit = {b_in[BP-1], b_in[k*MUL_CHUNK +: MUL_CHUNK]};
    end else begin : g_low
      assign digit = {1'b0, b_in[k*MUL_CHUNK +: MUL_CHUNK]};
    end

    assign part = a_in * digit;

    // Accumulate the weighted partial product
    always_ff @(posedge clk) begin
      if (en) begin
        acc_st[k] <= acc_in + (PW'(part) <<< (k * MUL_CHUNK));
      end
    end

    // Carry the operands to the next step
    if (k < NCH - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          a_st[k] <= a_in;
          b_st[k] <= b_in;
        end
      end
    end
  end

  assign p = acc_st[NCH-1][AW+BW-1:0];

endmodule

>>> hw/rtl/sli_div.sv
// Pipelined signed divider with truncation toward zero and saturation to
// QW bits: magnitude, range check, one quotient bit per stage, sign fix-up.
`timescale 1ns / 1ps

module sli_div #(
  parameter int NW = 101,
  parameter int DW = 67,
  parameter int QW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic signed [QW-1:0] quot,
  output logic                 sat
);

  localparam int RW = (NW > DW + QW + 1) ? NW : DW + QW + 1;
  localparam int NS = QW + 1;

  // Magnitude stage
  logic [NW-1:0] un_a;
  logic [DW-1:0] ud_a;
  logic          neg_a;

  always_ff @(posedge clk) begin
    if (en) begin
      un_a  <= num[NW-1] ? NW'(-num) : NW'(num);
      ud_a  <= den[DW-1] ? DW'(-den) : DW'(den);
      neg_a <= num[NW-1] ^ den[DW-1];
    end
  end

  // Range stage: flag quotients that need more than QW+1 bits
  logic [RW-1:0] rem_r;
  logic [DW-1:0] ud_r;
  logic          neg_r;
  logic          big_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= RW'(un_a);
      ud_r  <= ud_a;
      neg_r <= neg_a;
      big_r <= RW'(un_a) >= (RW'(ud_a) << NS);
    end
  end

  // Restoring steps, most significant quotient bit first
  logic [RW-1:0] rem_st [NS];
  logic [NS-1:0] q_st   [NS];
  logic [DW-1:0] ud_st  [NS];
  logic          neg_st [NS];
  logic          big_st [NS];

  for (genvar j = 0; j < NS; j++) begin : g_bit
    logic [RW-1:0] rem_in;
    logic [NS-1:0] q_in;
    logic [DW-1:0] ud_in;
    logic          neg_in;
    logic          big_in;
    logic [RW-1:0] shifted;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_in = rem_r;
      assign q_in   = '0;
      assign ud_in  = ud_r;
      assign neg_in = neg_r;
      assign big_in = big_r;
    end else begin : g_next
      assign rem_in = rem_st[j-1];
      assign q_in   = q_st[j-1];
      assign ud_in  = ud_st[j-1];
      assign neg_in = neg_st[j-1];
      assign big_in = big_st[j-1];
    end

    assign shifted = RW'(ud_in) << (QW - j);
    assign ge      = rem_in >= shifted;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_st[j] <= ge ? rem_in - shifted : rem_in;
        q_st[j]   <= {q_in[NS-2:0], ge};
        ud_st[j]  <= ud_in;
        neg_st[j] <= neg_in;
        big_st[j] <= big_in;
      end
    end
  end

  // Sign fix-up and clamp to the signed QW-bit range
  logic [NS-1:0] q_fin;
  logic          over_pos;
  logic          over_neg;

  assign q_fin    = q_st[NS-1];
  assign over_pos = big_st[NS-1] || q_fin[QW] || q_fin[QW-1];
  assign over_neg = big_st[NS-1] || q_fin[QW] || (q_fin[QW-1] && (|q_fin[QW-2:0]));

  always_ff @(posedge clk) begin
    if (en) begin
      if (!neg_st[NS-1]) begin
        quot <= over_pos ? {1'b0, {(QW-1){1'b1}}} : q_fin[QW-1:0];
        sat  <= over_pos;
      end else begin
        quot <= over_neg ? {1'b1, {(QW-1){1'b0}}} : -q_fin[QW-1:0];
        sat  <= over_neg;
      end
    end
  end

endmodule

>>> hw/rtl/sli_skid.sv
// Output register with a skid slot, parting the pipeline from the master side.
// No package dependencies.
`timescale 1ns / 1ps

module sli_skid #(
  parameter int WIDTH = 66
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             skid_valid;
  logic [WIDTH-1:0] skid_data;
  logic             load;

  // Output register may take a new word when empty or when being drained
  assign load = !out_valid || out_ready;
  assign room = !skid_valid;

  // Control: hold, refill from the skid slot, or catch the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

>>> hw/rtl/segment_line_intersection.sv
// Segment / clipping-line intersection, two-point form, signed fixed point.
// Throughput: one transaction per cycle unless the output buffer is full; the digit-serial multiplier stages and the
// one-bit-per-stage divider are all fully pipelined. A two-entry output buffer absorbs back-pressure.
// Reset (rst, synchronous): empties the pipeline and output buffer, near_depth = 7, far_depth = 5.0.
// Depends on sli_pkg, sli_mul, sli_div, sli_delay, sli_skid and the assertion macro header.
`timescale 1ns / 1ps
`include "segment_line_intersection_assert.svh"

module segment_line_intersection #(
  parameter int COORD_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  // Slave stream, one wall segment and clipping line per transaction
  input  logic s_tvalid,
  output logic s_tready,
  // seg_ax, seg_az, seg_bx, seg_bz, clip_near_x, clip_far_x (lowest first), zero padded
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  // Master stream, one intersection per transaction
  output logic m_tvalid,
  input  logic m_tready,
  // cross_x, cross_z (lowest first), zero padded
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
  // parallel, saturated (lowest first)
  output logic [sli_pkg::USER_W-1:0] m_tuser,
  // Configuration write port
  input  logic                           cfg_we,
  input  logic [sli_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [COORD_WIDTH-1:0]         cfg_wdata
);
  import sli_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int DW    = W + 1;
  localparam int PA    = 2 * DW;
  localparam int CW    = PA + 1;
  localparam int PB    = CW + DW;
  localparam int NW    = PB + 1;
  localparam int MA    = (DW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int DL    = W + 4;
  localparam int LAT   = 2 * MA + 3 + DL;
  localparam int OUT_W = ((2 * W + 7) / 8) * 8;

  localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

  // Configuration registers
  logic signed [W-1:0] near_depth;
  logic signed [W-1:0] far_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_depth <= W'(NEAR_DEPTH_RST);
      far_depth  <= W'(FAR_DEPTH_RST);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_NEAR_DEPTH: near_depth <= cfg_wdata;
        REG_FAR_DEPTH:  far_depth  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline advance and valid tracking
  logic           adv;
  logic           take;
  logic [LAT-1:0] vld;

  assign s_tready = adv;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], take};
    end
  end

  // Unpack the input transaction
  logic signed [W-1:0] in_ax, in_az, in_bx, in_bz, in_px, in_qx;

  assign in_ax = s_tdata[0*W +: W];
  assign in_az = s_tdata[1*W +: W];
  assign in_bx = s_tdata[2*W +: W];
  assign in_bz = s_tdata[3*W +: W];
  assign in_px = s_tdata[4*W +: W];
  assign in_qx = s_tdata[5*W +: W];

  // Stage 0: register coordinates and form the direction differences
  logic signed [W-1:0]  ax0, az0, bx0, bz0, px0, qx0, nz0, fz0;
  logic signed [DW-1:0] dx1_0, dz1_0, dx2_0, dz2_0;

  always_ff @(posedge clk) begin
    if (adv) begin
      ax0   <= in_ax;
      az0   <= in_az;
      bx0   <= in_bx;
      bz0   <= in_bz;
      px0   <= in_px;
      qx0   <= in_qx;
      nz0   <= near_depth;
      fz0   <= far_depth;
      dx1_0 <= DW'(in_ax) - DW'(in_bx);
      dz1_0 <= DW'(in_az) - DW'(in_bz);
      dx2_0 <= DW'(in_px) - DW'(in_qx);
      dz2_0 <= DW'(near_depth) - DW'(far_depth);
    end
  end

  // First product group: denominator and the two line constants
  logic signed [PA-1:0] pa_dd, pa_zx, pa_ab, pa_ba, pa_pf, pa_nq;

  sli_mul #(.AW(DW), .BW(DW)) u_mul_dd (
    .clk(clk), .en(adv), .a(dx1_0), .b(dz2_0), .p(pa_dd));
  sli_mul #(.AW(DW), .BW(DW)) u_mul_zx (
    .clk(clk), .en(adv), .a(dz1_0), .b(dx2_0), .p(pa_zx));
  sli_mul #(.AW(DW), .BW(DW)) u_mul_ab (
    .clk(clk), .en(adv), .a(DW'(ax0)), .b(DW'(bz0)), .p(pa_ab));
  sli_mul #(.AW(DW), .BW(DW)) u_mul_ba (
    .clk(clk), .en(adv), .a(DW'(az0)), .b(DW'(bx0)), .p(pa_ba));
  sli_mul #(.AW(DW), .BW(DW)) u_mul_pf (
    .clk(clk), .en(adv), .a(DW'(px0)), .b(DW'(fz0)), .p(pa_pf));
  sli_mul #(.AW(DW), .BW(DW)) u_mul_nq (
    .clk(clk), .en(adv), .a(DW'(nz0)), .b(DW'(qx0)), .p(pa_nq));

  // Align the differences with the second product group
  logic [4*DW-1:0]      diff_d;
  logic signed [DW-1:0] dx1_d, dz1_d, dx2_d, dz2_d;

  sli_delay #(.WIDTH(4*DW), .DEPTH(MA+1)) u_dly_diff (
    .clk(clk), .en(adv), .d({dz2_0, dx2_0, dz1_0, dx1_0}), .q(diff_d));

  assign dx1_d = diff_d[0*DW +: DW];
  assign dz1_d = diff_d[1*DW +: DW];
  assign dx2_d = diff_d[2*DW +: DW];
  assign dz2_d = diff_d[3*DW +: DW];

  // Cross-product differences of the first group
  logic signed [CW-1:0] den_a, c1, c2;

  always_ff @(posedge clk) begin
    if (adv) begin
      den_a <= CW'(pa_dd) - CW'(pa_zx);
      c1    <= CW'(pa_ab) - CW'(pa_ba);
      c2    <= CW'(pa_pf) - CW'(pa_nq);
    end
  end

  // Second product group: numerators
  logic signed [PB-1:0] pb_c1x, pb_c2x, pb_c1z, pb_c2z;

  sli_mul #(.AW(CW), .BW(DW)) u_mul_c1x (
    .clk(clk), .en(adv), .a(c1), .b(dx2_d), .p(pb_c1x));
  sli_mul #(.AW(CW), .BW(DW)) u_mul_c2x (
    .clk(clk), .en(adv), .a(c2), .b(dx1_d), .p(pb_c2x));
  sli_mul #(.AW(CW), .BW(DW)) u_mul_c1z (
    .clk(clk), .en(adv), .a(c1), .b(dz2_d), .p(pb_c1z));
  sli_mul #(.AW(CW), .BW(DW)) u_mul_c2z (
    .clk(clk), .en(adv), .a(c2), .b(dz1_d), .p(pb_c2z));

  // Carry the denominator alongside the numerators
  logic [CW-1:0]        den_d;
  logic signed [CW-1:0] den_b;

  sli_delay #(.WIDTH(CW), .DEPTH(MA+1)) u_dly_den (
    .clk(clk), .en(adv), .d(den_a), .q(den_d));

  assign den_b = den_d;

  logic signed [NW-1:0] num_x, num_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      num_x <= NW'(pb_c1x) - NW'(pb_c2x);
      num_z <= NW'(pb_c1z) - NW'(pb_c2z);
    end
  end

  // Parallel lines: zero denominator, flag carried through the divider depth
  logic den_zero;
  logic par_d;

  assign den_zero = (den_b == '0);

  sli_delay #(.WIDTH(1), .DEPTH(DL)) u_dly_par (
    .clk(clk), .en(adv), .d(den_zero), .q(par_d));

  // Dividers for both coordinates
  logic signed [W-1:0] q_x, q_z;
  logic                sat_x, sat_z;

  sli_div #(.NW(NW), .DW(CW), .QW(W)) u_div_x (
    .clk(clk), .en(adv), .num(num_x), .den(den_b), .quot(q_x), .sat(sat_x));
  sli_div #(.NW(NW), .DW(CW), .QW(W)) u_div_z (
    .clk(clk), .en(adv), .num(num_z), .den(den_b), .quot(q_z), .sat(sat_z));

  // Build the result word; parallel lines override the quotients
  logic [W-1:0]            res_x, res_z;
  logic [USER_W-1:0]       res_user;
  logic [OUT_W+USER_W-1:0] res_word;
  logic [OUT_W+USER_W-1:0] out_word;

  always_comb begin
    res_x                    = par_d ? '0 : q_x;
    res_z                    = par_d ? '0 : q_z;
    res_user                 = '0;
    res_user[USER_PARALLEL]  = par_d;
    res_user[USER_SATURATED] = !par_d && (sat_x || sat_z);
  end

  assign res_word = {res_user, OUT_W'({res_z, res_x})};

  // Output register and skid slot
  sli_skid #(.WIDTH(OUT_W + USER_W)) u_skid (
    .clk(clk),
    .rst(rst),
    .push(adv && vld[LAT-1]),
    .push_data(res_word),
    .room(adv),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data(out_word)
  );

  assign m_tdata = out_word[OUT_W-1:0];
  assign m_tuser = out_word[OUT_W +: USER_W];

  // Checks
  `SLI_ASSERT_IMPL(a_parallel_zero, m_tvalid && m_tuser[USER_PARALLEL], (m_tdata == '0) && !m_tuser[USER_SATURATED], "parallel result must carry zero coordinates and no saturation")
  `SLI_ASSERT_IMPL(a_sat_at_limit, m_tvalid && m_tuser[USER_SATURATED], (m_tdata[W-1:0] == SAT_MAX) || (m_tdata[W-1:0] == SAT_MIN) || (m_tdata[2*W-1:W] == SAT_MAX) || (m_tdata[2*W-1:W] == SAT_MIN), "saturated result must hold a range limit")
  `SLI_ASSERT_IMPL(a_stall_has_output, !s_tready, m_tvalid, "input stalled while output register empty")
  `SLI_ASSERT_NEXT(a_tail_held, vld[LAT-1] && !adv, vld[LAT-1], "finished item lost while pipeline stalled")

endmodule

>>> verif/crossing_checker.sv
// Checker for the segment / clipping-line intersection block: watches both streams and the
// register port, predicts each crossing point and compares it with what the block returns.
// Depends on sli_pkg for register indexes, reset values and result flag positions.
`timescale 1ns / 1ps

module crossing_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [191:0]                   s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [63:0]                    m_tdata,
  input  logic [sli_pkg::USER_W-1:0]     m_tuser,
  input  logic                           cfg_we,
  input  logic [sli_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [31:0]                    cfg_wdata,
  output int unsigned                    failures,
  output int unsigned                    outstanding
);
  import sli_pkg::*;

  typedef logic signed [31:0]  coord_t;
  // Wide enough for every exact product and sum of the two-point form
  typedef logic signed [159:0] wide_t;

  // First field in the lowest bits of tdata
  typedef struct packed {
    coord_t clip_far_x;
    coord_t clip_near_x;
    coord_t seg_bz;
    coord_t seg_bx;
    coord_t seg_az;
    coord_t seg_ax;
  } wall_t;

  typedef struct packed {
    coord_t x;
    coord_t z;
    logic   is_parallel;
    logic   clamped;
  } crossing_t;

  localparam wide_t COORD_HI = (wide_t'(1) <<< 31) - 1;
  localparam wide_t COORD_LO = -(wide_t'(1) <<< 31);

  coord_t      near_depth;
  coord_t      far_depth;
  crossing_t   expected_crossings[$];
  int unsigned mismatches = 0;
  int unsigned queued = 0;

  assign failures    = mismatches;
  assign outstanding = queued;

  // Clamp a raw quotient into the coordinate range, flag when it had to
  function automatic coord_t clamp_coord(input wide_t q, output logic hit);
    hit = 1'b0;
    if (q > COORD_HI) begin
      hit = 1'b1;
      return coord_t'(COORD_HI);
    end
    if (q < COORD_LO) begin
      hit = 1'b1;
      return coord_t'(COORD_LO);
    end
    return coord_t'(q);
  endfunction

  // Crossing of the wall line with the clipping line (raw scale cancels out)
  function automatic crossing_t clip_crossing(input wall_t w, input coord_t nz_c,
                                              input coord_t fz_c);
    wide_t     ax, az, bx, bz, px, qx, nz, fz;
    wide_t     dx1, dz1, dx2, dz2, den, c1, c2, num_x, num_z;
    logic      hit_x, hit_z;
    crossing_t res;
    ax  = w.seg_ax;
    az  = w.seg_az;
    bx  = w.seg_bx;
    bz  = w.seg_bz;
    px  = w.clip_near_x;
    qx  = w.clip_far_x;
    nz  = nz_c;
    fz  = fz_c;
    dx1 = ax - bx;
    dz1 = az - bz;
    dx2 = px - qx;
    dz2 = nz - fz;
    den = dx1 * dz2 - dz1 * dx2;
    res = '0;
    if (den == 0) begin
      res.is_parallel = 1'b1;
      return res;
    end
    c1    = ax * bz - az * bx;
    c2    = px * fz - nz * qx;
    num_x = c1 * dx2 - dx1 * c2;
    num_z = c1 * dz2 - dz1 * c2;
    // Signed division truncates toward zero
    res.x       = clamp_coord(num_x / den, hit_x);
    res.z       = clamp_coord(num_z / den, hit_z);
    res.clamped = hit_x | hit_z;
    return res;
  endfunction

  task automatic report(input string what, input bit have_want, input crossing_t want,
                        input crossing_t got);
    mismatches++;
    if (mismatches <= 10) begin
      if (have_want)
        $display("[%0t] %s: expected x=%0d z=%0d parallel=%0b saturated=%0b, got x=%0d z=%0d parallel=%0b saturated=%0b",
                 $realtime, what, want.x, want.z, want.is_parallel, want.clamped,
                 got.x, got.z, got.is_parallel, got.clamped);
      else
        $display("[%0t] %s: got x=%0d z=%0d parallel=%0b saturated=%0b",
                 $realtime, what, got.x, got.z, got.is_parallel, got.clamped);
    end
  endtask

  // Track registers, predict on each input transaction, compare each output transaction
  always @(posedge clk) begin : watch
    crossing_t got;
    crossing_t want;
    if (rst) begin
      near_depth = coord_t'(NEAR_DEPTH_RST);
      far_depth  = coord_t'(FAR_DEPTH_RST);
      expected_crossings.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_NEAR_DEPTH: near_depth = cfg_wdata;
          REG_FAR_DEPTH:  far_depth  = cfg_wdata;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.x           = m_tdata[31:0];
        got.z           = m_tdata[63:32];
        got.is_parallel = m_tuser[USER_PARALLEL];
        got.clamped     = m_tuser[USER_SATURATED];
        if (expected_crossings.size() == 0) begin
          report("unexpected result", 1'b0, '0, got);
        end else begin
          want = expected_crossings.pop_front();
          if (got.x !== want.x || got.z !== want.z ||
              got.is_parallel !== want.is_parallel || got.clamped !== want.clamped)
            report("result mismatch", 1'b1, want, got);
        end
      end
      if (s_tvalid && s_tready)
        expected_crossings.push_back(clip_crossing(s_tdata, near_depth, far_depth));
    end
    queued = expected_crossings.size();
  end

endmodule

>>> verif/segment_line_intersection_test.sv
// Top of the segment / clipping-line intersection testbench: clock, reset, stimulus,
// back-pressure and the verdict. Depends on sli_pkg, the block itself and crossing_checker.
`timescale 1ns / 1ps

module segment_line_intersection_test;
  import sli_pkg::*;

  localparam int COORD_W      = 32;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 60;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t C_MAX = 32'sh7FFF_FFFF;
  localparam coord_t C_MIN = 32'sh8000_0000;
  localparam coord_t ONE   = 32'sd65536;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [191:0]          s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [63:0]           m_tdata;
  logic [USER_W-1:0]     m_tuser;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [31:0]           cfg_wdata;
  int unsigned           failures;
  int unsigned           outstanding;

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  bit          hold_request;
  coord_t      cur_near;
  coord_t      cur_far;

  segment_line_intersection #(.COORD_WIDTH(COORD_W)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  crossing_checker crossing_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .failures(failures), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Give up long after the slowest correct run would have ended
  initial begin
    #4_000_000;
    $display("segment_line_intersection verification failed");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off counted here on request
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic coord_t small_coord();
    return coord_t'(int'($urandom_range(1048576)) - 524288);
  endfunction

  function automatic coord_t pick_extreme();
    case ($urandom_range(5))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return '0;
      3:       return -1;
      4:       return 1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Offer one wall and clipping line, after a random idle gap; starts and ends at a falling edge
  task automatic offer_wall(input coord_t ax, input coord_t az, input coord_t bx,
                            input coord_t bz, input coord_t px, input coord_t qx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {qx, px, bz, bx, az, ax};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Mostly plausible view-space walls, with parallel, near-parallel and extreme cases mixed in
  task automatic offer_random_wall();
    coord_t      ax, az, bx, bz, px, qx;
    int unsigned kind;
    kind = $urandom_range(9);
    ax   = small_coord();
    az   = small_coord();
    bx   = small_coord();
    bz   = small_coord();
    px   = small_coord();
    qx   = small_coord();
    case (kind)
      4, 9: begin
        ax = coord_t'($urandom);
        az = coord_t'($urandom);
        bx = coord_t'($urandom);
        bz = coord_t'($urandom);
        px = coord_t'($urandom);
        qx = coord_t'($urandom);
      end
      5: begin
        // Parallel: both vertical, or wall direction equal to the clipping direction
        if ($urandom_range(1)) begin
          bx = ax;
          qx = px;
        end else begin
          bx = ax - (px - qx);
          bz = az - (cur_near - cur_far);
        end
      end
      6: begin
        // Nearly parallel to a vertical clipping line: the depth runs far out of range
        bx = $urandom_range(1) ? ax + 1 : ax - 1;
        az = coord_t'($urandom);
        bz = coord_t'($urandom);
        qx = px;
      end
      7: begin
        ax = pick_extreme();
        az = pick_extreme();
        bx = pick_extreme();
        bz = pick_extreme();
        px = pick_extreme();
        qx = pick_extreme();
      end
      8: begin
        px = coord_t'($urandom);
        qx = coord_t'($urandom);
      end
      default: ;
    endcase
    offer_wall(ax, az, bx, bz, px, qx);
  endtask

  // Stop offering and hold until every expected result has come, then let the pipe settle
  task automatic await_results();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_depths(input coord_t near_val, input coord_t far_val);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_NEAR_DEPTH;
    cfg_wdata <= near_val;
    @(negedge clk);
    cfg_addr  <= REG_FAR_DEPTH;
    cfg_wdata <= far_val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_near  = near_val;
    cur_far   = far_val;
  endtask

  task automatic run_phase(input coord_t near_val, input coord_t far_val,
                           input int unsigned idle, input int unsigned stall,
                           input int unsigned count, input bit hold_off, input bit pause_mid);
    int unsigned i;
    await_results();
    write_depths(near_val, far_val);
    send_idle_pct = idle;
    stall_pct     = stall;
    if (hold_off)
      hold_request = 1'b1;
    for (i = 0; i < count; i++) begin
      if (pause_mid && i == count / 2)
        await_results();
      offer_random_wall();
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    cfg_we        = 1'b0;
    cfg_addr      = REG_NEAR_DEPTH;
    cfg_wdata     = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 1'b0;
    cur_near      = coord_t'(NEAR_DEPTH_RST);
    cur_far       = coord_t'(FAR_DEPTH_RST);
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed walls under the reset depths
    offer_wall('0, '0, '0, '0, '0, '0);
    offer_wall(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    offer_wall(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
    offer_wall(-2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE, '0, '0);
    offer_wall(-3 * ONE, ONE, ONE, 4 * ONE, ONE / 2, -3 * ONE / 2);
    // vertical wall beside a vertical clipping line
    offer_wall(ONE, ONE, ONE, 3 * ONE, -ONE, -ONE);
    // steep wall: depth clamps at the low and then the high end
    offer_wall(1, -(32'sd1 <<< 30), 2, 32'sd1 <<< 30, '0, '0);
    offer_wall(1, 32'sd1 <<< 30, 2, -(32'sd1 <<< 30), '0, '0);
    offer_wall(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX);
    offer_wall(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN);
    offer_wall(-1, -1, 1, 1, C_MAX, C_MIN);
    // wall shrunk to a point
    offer_wall(5 * ONE, 2 * ONE, 5 * ONE, 2 * ONE, ONE, -ONE);
    // inexact quotients
    offer_wall(-5, 3, 7, -2, 1, -3);
    offer_wall(ONE, 32'sh7FFF_0000, -ONE, 32'sh7FFF_0000, C_MAX, C_MIN);

    run_phase(C_MIN, C_MAX, 0, 0, 100, 1'b1, 1'b0);
    run_phase(C_MAX, C_MIN, 51, 0, 100, 1'b0, 1'b1);
    run_phase('0, '0, 0, 51, 100, 1'b0, 1'b0);
    run_phase(coord_t'($urandom), coord_t'($urandom), 11, 11, 100, 1'b0, 1'b0);
    run_phase(-ONE, 3 * ONE, 0, 0, 100, 1'b0, 1'b0);
    await_results();

    if (failures == 0 && outstanding == 0)
      $display("segment_line_intersection verification clean");
    else
      $display("segment_line_intersection verification failed");
    $finish;
  end

endmodule
